// ===== rtl/tcr_pkg.sv =====
`default_nettype none

package tcr_pkg;

   // Item kinds carried on req_tuser
   typedef enum logic {
      KIND_TICK   = 1'b0,
      KIND_RENDER = 1'b1
   } kind_type;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_LINE_MODE_400 = 3'd0,
      REG_COLOR_MODE    = 3'd1,
      REG_WIDE_CELLS    = 3'd2,
      REG_TALL_CELLS    = 3'd3,
      REG_CURSOR_ENABLE = 3'd4,
      REG_CURSOR_STEADY = 3'd5,
      REG_CURSOR_TOP    = 3'd6,
      REG_CURSOR_BOTTOM = 3'd7
   } reg_index_type;

   localparam int unsigned NUM_PIXELS  = 16;
   localparam int unsigned PIXEL_BITS  = 4;
   localparam int unsigned REQ_BITS    = 24;
   localparam int unsigned RSP_BITS    = 72;
   localparam int unsigned ADDR_BITS   = 5;

   localparam logic [3:0] CURSOR_COLOUR = 4'd7;
   localparam logic [3:0] MONO_COLOUR   = 4'd7;

   // Cell geometry, 400-line rules
   localparam logic [4:0] H400_SHORT  = 5'd16;
   localparam logic [4:0] H400_TALL   = 5'd20;
   localparam logic [4:0] VL400_SHORT = 5'd16;
   localparam logic [4:0] VL400_TALL  = 5'd18;
   localparam logic [4:0] UL400_SHORT = 5'd15;
   localparam logic [4:0] UL400_TALL  = 5'd17;
   // Cell geometry, 200-line rules
   localparam logic [4:0] H200_SHORT  = 5'd8;
   localparam logic [4:0] H200_TALL   = 5'd10;
   localparam logic [4:0] VL200_SHORT = 5'd8;
   localparam logic [4:0] VL200_TALL  = 5'd9;
   localparam logic [4:0] UL200_SHORT = 5'd7;
   localparam logic [4:0] UL200_TALL  = 5'd8;

endpackage

`default_nettype wire

// ===== rtl/text_cell_row_renderer.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         tvalid/tready          tuser: kind; tdata: cell row request
// rsp_      out        tvalid/tready          tdata: pixels, blink_on
// csr_      in (APB)   psel/penable/pready    8 registers at 4*i, 32-bit data
//
// The result is computed between the request inputs and the result
// register, and a new request is taken every cycle while the result
// register is empty or being drained in the same cycle.
// Frame ticks produce no result; they only advance the 5-bit blink counter.
// Synchronous active-high reset clears the registers to their defaults,
// the blink counter and the result valid flag.
// A stalled result holds rsp_tdata; req_tready falls only while it waits.
module text_cell_row_renderer
   import tcr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request: {cursor_here, cell_row[4:0], is_kanji, attribute[3:0], glyph_row[7:0]}
   //          from bit 0 up: glyph_row, attribute, is_kanji, cell_row, cursor_here
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [REQ_BITS-1:0]  req_tdata,
   input  wire logic                 req_tuser,   // kind: 0 frame tick, 1 render
   // result: from bit 0 up: pixels[63:0], blink_on, zero fill
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [RSP_BITS-1:0]  rsp_tdata,
   // configuration
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output      logic [31:0]          csr_prdata,
   output      logic                 csr_pready
);

   // configuration registers
   logic       line_mode_400_ff, color_mode_ff, wide_cells_ff, tall_cells_ff;
   logic       cursor_enable_ff, cursor_steady_ff;
   logic [4:0] cursor_top_ff, cursor_bottom_ff;

   logic [4:0] blink_counter_ff, blink_counter_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NUM_PIXELS*PIXEL_BITS-1:0] pixels_ff, pixels_in;
   logic                      blink_on_ff;

   reg_index_type csr_index;
   logic          csr_write;

   // request fields
   logic [7:0] glyph_row;
   logic [3:0] attribute;
   logic       is_kanji;
   logic [4:0] cell_row;
   logic       cursor_here;

   logic req_accept, render_accept, tick_accept;
   logic blink_on;

   logic [4:0] height, vl_rows, ul_row;
   logic       in_pattern;
   logic [3:0] colour;
   logic       reverse, vline, uline, cursor_fill;
   logic [7:0] pattern;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_BITS-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_400_ff <= 1'b1;
         color_mode_ff    <= 1'b0;
         wide_cells_ff    <= 1'b0;
         tall_cells_ff    <= 1'b0;
         cursor_enable_ff <= 1'b0;
         cursor_steady_ff <= 1'b0;
         cursor_top_ff    <= 5'd0;
         cursor_bottom_ff <= 5'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LINE_MODE_400: line_mode_400_ff <= csr_pwdata[0];
            REG_COLOR_MODE:    color_mode_ff    <= csr_pwdata[0];
            REG_WIDE_CELLS:    wide_cells_ff    <= csr_pwdata[0];
            REG_TALL_CELLS:    tall_cells_ff    <= csr_pwdata[0];
            REG_CURSOR_ENABLE: cursor_enable_ff <= csr_pwdata[0];
            REG_CURSOR_STEADY: cursor_steady_ff <= csr_pwdata[0];
            REG_CURSOR_TOP:    cursor_top_ff    <= csr_pwdata[4:0];
            REG_CURSOR_BOTTOM: cursor_bottom_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      unique case (csr_index)
         REG_LINE_MODE_400: csr_prdata[0]   = line_mode_400_ff;
         REG_COLOR_MODE:    csr_prdata[0]   = color_mode_ff;
         REG_WIDE_CELLS:    csr_prdata[0]   = wide_cells_ff;
         REG_TALL_CELLS:    csr_prdata[0]   = tall_cells_ff;
         REG_CURSOR_ENABLE: csr_prdata[0]   = cursor_enable_ff;
         REG_CURSOR_STEADY: csr_prdata[0]   = cursor_steady_ff;
         REG_CURSOR_TOP:    csr_prdata[4:0] = cursor_top_ff;
         REG_CURSOR_BOTTOM: csr_prdata[4:0] = cursor_bottom_ff;
         default:           csr_prdata      = 32'd0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   // Ticks are taken under the same ready as renders; keeps ordering simple.
   assign req_tready    = ~rsp_valid_ff | rsp_tready;
   assign req_accept    = req_tvalid & req_tready;
   assign render_accept = req_accept & (kind_type'(req_tuser) == KIND_RENDER);
   assign tick_accept   = req_accept & (kind_type'(req_tuser) == KIND_TICK);

   assign glyph_row   = req_tdata[7:0];
   assign attribute   = req_tdata[11:8];
   assign is_kanji    = req_tdata[12];
   assign cell_row    = req_tdata[17:13];
   assign cursor_here = req_tdata[18];

   assign blink_on         = blink_counter_ff[4];
   assign blink_counter_in = blink_counter_ff + 5'd1;   // wraps modulo 32

   // --------------------------------------------------------- cell rules
   always_comb begin
      if (line_mode_400_ff) begin
         height     = tall_cells_ff ? H400_TALL   : H400_SHORT;
         vl_rows    = tall_cells_ff ? VL400_TALL  : VL400_SHORT;
         ul_row     = tall_cells_ff ? UL400_TALL  : UL400_SHORT;
         in_pattern = ~cell_row[4];            // row < 16
      end else begin
         height     = tall_cells_ff ? H200_TALL   : H200_SHORT;
         vl_rows    = tall_cells_ff ? VL200_TALL  : VL200_SHORT;
         ul_row     = tall_cells_ff ? UL200_TALL  : UL200_SHORT;
         in_pattern = (cell_row[4:3] == 2'b00); // row < 8
      end
   end

   // colour and monochrome effects
   always_comb begin
      if (color_mode_ff) begin
         if (line_mode_400_ff) begin
            colour = {1'b1, is_kanji ? ~attribute[2:0] : attribute[2:0]};
         end else begin
            colour = (attribute[2:0] == 3'd0) ? 4'd7 : {1'b0, attribute[2:0]};
         end
         vline   = 1'b0;
         uline   = 1'b0;
         reverse = 1'b0;
      end else begin
         colour  = MONO_COLOUR;
         vline   = attribute[0];
         uline   = attribute[1];
         reverse = attribute[2];
      end
      // blinking cells flip reverse during the lit phase
      reverse = reverse ^ (attribute[3] & blink_on);
   end

   assign pattern = reverse ? ~glyph_row : glyph_row;

   assign cursor_fill = cursor_here & cursor_enable_ff & (cursor_steady_ff | ~blink_on)
                      & (cell_row >= cursor_top_ff) & (cell_row < cursor_bottom_ff)
                      & (cell_row < height);

   // Per-pixel priority: cursor, underline, vertical line, glyph dot.
   for (genvar i = 0; i < NUM_PIXELS; i++) begin : g_pixel
      logic       active, dot, last;
      logic [2:0] dot_index;

      assign active    = wide_cells_ff | (i < NUM_PIXELS/2);
      assign dot_index = wide_cells_ff ? 3'(i >> 1) : 3'(i % 8);
      assign dot       = pattern[3'd7 - dot_index] & in_pattern;
      assign last      = wide_cells_ff ? (i == NUM_PIXELS-1) : (i == NUM_PIXELS/2-1);

      always_comb begin
         if (!active) begin
            pixels_in[i*PIXEL_BITS +: PIXEL_BITS] = 4'd0;
         end else if (cursor_fill) begin
            pixels_in[i*PIXEL_BITS +: PIXEL_BITS] = CURSOR_COLOUR;
         end else if (uline && cell_row == ul_row) begin
            pixels_in[i*PIXEL_BITS +: PIXEL_BITS] = colour;
         end else if (vline && last && cell_row < vl_rows) begin
            pixels_in[i*PIXEL_BITS +: PIXEL_BITS] = colour;
         end else if (dot) begin
            pixels_in[i*PIXEL_BITS +: PIXEL_BITS] = colour;
         end else begin
            pixels_in[i*PIXEL_BITS +: PIXEL_BITS] = 4'd0;
         end
      end
   end

   // ----------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (render_accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         blink_counter_ff <= 5'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (tick_accept) begin
            blink_counter_ff <= blink_counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (render_accept) begin
         pixels_ff   <= pixels_in;
         blink_on_ff <= blink_on;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, blink_on_ff, pixels_ff};

endmodule

`default_nettype wire

// ===== rtl/tcr_checker.sv =====
`default_nettype none

module tcr_checker
   import tcr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic                req_tuser,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RSP_BITS-1:0] rsp_tdata
);

   logic render_in;
   assign render_in = req_tvalid & req_tready & (kind_type'(req_tuser) == KIND_RENDER);

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // accepted render shows a result next cycle
   a_render_result: assert property (@(posedge clock) disable iff (reset)
      render_in |=> rsp_tvalid)
      else $error("render request produced no result");

   // drained result with no new render leaves the output empty
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !render_in) |=> !rsp_tvalid)
      else $error("result appeared without a render request");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind text_cell_row_renderer tcr_checker u_tcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/text_cell_row_renderer_tb.sv =====
`default_nettype none

module text_cell_row_renderer_tb;
   import tcr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any handshake before the run is abandoned. The longest
   // legal quiet spell is the receiver hold-off plus a few register writes.
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam logic [3:0]  WHITE       = 4'd7;

   // Request payload, packed from bit 0 up: glyph_row, attribute, is_kanji,
   // cell_row, cursor_here
   typedef struct packed {
      logic       cursor_here;
      logic [4:0] cell_row;
      logic       is_kanji;
      logic [3:0] attribute;
      logic [7:0] glyph_row;
   } cell_fields_type;

   localparam int unsigned REQ_FIELD_BITS = $bits(cell_fields_type);

   typedef struct {
      kind_type        kind;
      cell_fields_type f;
   } cell_request_type;

   typedef struct {
      logic [63:0] pixels;
      logic        blink_on;
   } row_pixels_type;

   logic clock = 1'b0;
   logic reset;

   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_BITS-1:0]  req_tdata;   // glyph_row, attribute, is_kanji, cell_row, cursor_here
   logic                 req_tuser;   // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_BITS-1:0]  rsp_tdata;   // pixels[63:0], blink_on, zero fill
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   text_cell_row_renderer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block's settings and blink counter
   logic       rule_400     = 1'b1;
   logic       colour_on    = 1'b0;
   logic       double_dots  = 1'b0;
   logic       tall         = 1'b0;
   logic       cursor_on    = 1'b0;
   logic       cursor_solid = 1'b0;
   logic [4:0] cursor_first = 5'd0;
   logic [4:0] cursor_limit = 5'd0;
   logic [4:0] frame_count  = 5'd0;

   cell_request_type pending_requests[$];
   row_pixels_type   expected_rows[$];

   // Handshake bookkeeping shared between the clocked processes
   bit          req_taken   = 1'b0;
   bit          rsp_taken   = 1'b0;
   bit          req_no_gaps = 1'b0;
   bit          rsp_no_gaps = 1'b0;
   int unsigned req_wait    = 0;
   int unsigned rsp_wait    = 0;
   int unsigned hold_left   = 0;
   int unsigned quiet_count = 0;
   int unsigned row_errors  = 0;

   bit               offer;
   bit               progress;
   cell_request_type next_req;
   row_pixels_type   want;

   // Expected pixels of one cell row under the current settings
   function automatic row_pixels_type render_cell_row(input cell_fields_type c);
      row_pixels_type r;
      logic        blink;
      logic [4:0]  height;
      logic [4:0]  pat_rows;
      logic [4:0]  vl_rows;
      logic [4:0]  ul_row;
      logic [3:0]  colour;
      logic        vline;
      logic        uline;
      logic        rev;
      logic [7:0]  pat;
      int          npx;
      int          dot;
      int          i;
      blink = frame_count[4];
      if (rule_400) begin
         height   = tall ? H400_TALL : H400_SHORT;
         pat_rows = H400_SHORT;
         vl_rows  = tall ? VL400_TALL : VL400_SHORT;
         ul_row   = tall ? UL400_TALL : UL400_SHORT;
      end else begin
         height   = tall ? H200_TALL : H200_SHORT;
         pat_rows = H200_SHORT;
         vl_rows  = tall ? VL200_TALL : VL200_SHORT;
         ul_row   = tall ? UL200_TALL : UL200_SHORT;
      end
      if (colour_on) begin
         // kanji cells take the inverted colour in 400-line mode
         if (rule_400)
            colour = {1'b1, c.is_kanji ? ~c.attribute[2:0] : c.attribute[2:0]};
         else
            colour = (c.attribute[2:0] != 3'd0) ? {1'b0, c.attribute[2:0]} : WHITE;
         vline = 1'b0;
         uline = 1'b0;
         rev   = 1'b0;
      end else begin
         colour = MONO_COLOUR;
         vline  = c.attribute[0];
         uline  = c.attribute[1];
         rev    = c.attribute[2];
      end
      if (c.attribute[3] && blink)
         rev = !rev;
      npx      = double_dots ? 16 : 8;
      r.pixels = '0;
      if (c.cell_row < pat_rows) begin
         pat = rev ? ~c.glyph_row : c.glyph_row;
         for (i = 0; i < npx; i++) begin
            dot = double_dots ? i / 2 : i;
            if (pat[7 - dot])
               r.pixels[i*4 +: 4] = colour;
         end
      end
      if (vline && c.cell_row < vl_rows)
         r.pixels[(npx-1)*4 +: 4] = colour;
      if (uline && c.cell_row == ul_row)
         for (i = 0; i < npx; i++)
            r.pixels[i*4 +: 4] = colour;
      // cursor goes on top of everything; empty span when limit <= first
      if (c.cursor_here && cursor_on && (cursor_solid || !blink) &&
          c.cell_row >= cursor_first && c.cell_row < cursor_limit && c.cell_row < height)
         for (i = 0; i < npx; i++)
            r.pixels[i*4 +: 4] = CURSOR_COLOUR;
      r.blink_on = blink;
      return r;
   endfunction

   // Request driver: one gap per request, drawn when it is loaded
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_taken) begin
            req_taken = 1'b0;
            offer     = 1'b0;
         end
         if (!offer) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_requests.size() != 0) begin
               next_req = pending_requests.pop_front();
               offer    = 1'b1;
               req_wait = req_no_gaps ? 0 : $urandom_range(0, 7);
               req_tdata <= REQ_BITS'(next_req.f);
               req_tuser <= next_req.kind;
            end
         end
         req_tvalid <= offer;
      end
   end

   // Result sink: per-result stall, plus the long hold-off when asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait  = rsp_no_gaps ? 0 : $urandom_range(0, 7);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         if (hold_left > 0)
            hold_left--;
         rsp_tready <= (rsp_wait == 0) && (hold_left == 0);
      end
   end

   // Monitor: checks results, predicts accepted requests, watches for a hang
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            progress  = 1'b1;
            rsp_taken = 1'b1;
            if (expected_rows.size() == 0) begin
               if (row_errors < 10)
                  $display("%0t: result with nothing expected: pixels %h blink_on %0b",
                           $realtime, rsp_tdata[63:0], rsp_tdata[64]);
               row_errors++;
            end else begin
               want = expected_rows.pop_front();
               if (rsp_tdata[63:0] !== want.pixels || rsp_tdata[64] !== want.blink_on) begin
                  if (row_errors < 10)
                     $display("%0t: mismatch: pixels exp %h got %h, blink_on exp %0b got %0b",
                              $realtime, want.pixels, rsp_tdata[63:0],
                              want.blink_on, rsp_tdata[64]);
                  row_errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            progress  = 1'b1;
            req_taken = 1'b1;
            if (kind_type'(req_tuser) == KIND_TICK)
               frame_count = frame_count + 5'd1;
            else
               expected_rows.push_back(
                  render_cell_row(cell_fields_type'(req_tdata[REQ_FIELD_BITS-1:0])));
         end
         quiet_count = progress ? 0 : quiet_count + 1;
         if (quiet_count >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // APB write; upper bits carry junk that the block must mask off
   task automatic csr_write(input reg_index_type idx, input logic [4:0] value);
      logic [31:0] word;
      word = $urandom;
      if (idx == REG_CURSOR_TOP || idx == REG_CURSOR_BOTTOM)
         word[4:0] = value;
      else
         word[0] = value[0];
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_LINE_MODE_400: rule_400     = word[0];
         REG_COLOR_MODE:    colour_on    = word[0];
         REG_WIDE_CELLS:    double_dots  = word[0];
         REG_TALL_CELLS:    tall         = word[0];
         REG_CURSOR_ENABLE: cursor_on    = word[0];
         REG_CURSOR_STEADY: cursor_solid = word[0];
         REG_CURSOR_TOP:    cursor_first = word[4:0];
         REG_CURSOR_BOTTOM: cursor_limit = word[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input logic l400, input logic col, input logic wide,
                                 input logic tl, input logic en, input logic stdy,
                                 input logic [4:0] top, input logic [4:0] bot);
      csr_write(REG_LINE_MODE_400, l400);
      csr_write(REG_COLOR_MODE, col);
      csr_write(REG_WIDE_CELLS, wide);
      csr_write(REG_TALL_CELLS, tl);
      csr_write(REG_CURSOR_ENABLE, en);
      csr_write(REG_CURSOR_STEADY, stdy);
      csr_write(REG_CURSOR_TOP, top);
      csr_write(REG_CURSOR_BOTTOM, bot);
   endtask

   task automatic push_render(input logic [7:0] glyph, input logic [3:0] attr,
                              input logic kanji, input logic [4:0] row, input logic here);
      cell_request_type r;
      r.kind          = KIND_RENDER;
      r.f.glyph_row   = glyph;
      r.f.attribute   = attr;
      r.f.is_kanji    = kanji;
      r.f.cell_row    = row;
      r.f.cursor_here = here;
      pending_requests.push_back(r);
   endtask

   // Roughly one frame tick per four requests so the blink phase turns over
   task automatic push_random(input int unsigned count);
      cell_request_type r;
      repeat (count) begin
         r.kind = ($urandom_range(0, 3) == 0) ? KIND_TICK : KIND_RENDER;
         r.f    = REQ_FIELD_BITS'($urandom_range(0, (1 << REQ_FIELD_BITS) - 1));
         // mostly rows inside a cell, the rest anywhere in the field
         if ($urandom_range(0, 4) != 0)
            r.f.cell_row = 5'($urandom_range(0, 19));
         pending_requests.push_back(r);
      end
   endtask

   // Wait until the block is idle: nothing queued, offered or outstanding
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_rows.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [4:0] top;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, on reset settings: 400-line mono, narrow, short, no cursor
      push_render(8'h00, 4'h0, 1'b0, 5'd0,  1'b0);
      push_render(8'hff, 4'h0, 1'b0, 5'd0,  1'b0);
      push_render(8'h81, 4'h4, 1'b0, 5'd3,  1'b0);   // reverse
      push_render(8'h3c, 4'h1, 1'b0, 5'd15, 1'b0);   // vline, last pattern row
      push_render(8'h3c, 4'h1, 1'b0, 5'd16, 1'b0);   // past vline and pattern
      push_render(8'h00, 4'h2, 1'b0, 5'd15, 1'b0);   // underline row
      push_render(8'haa, 4'h8, 1'b1, 5'd5,  1'b0);   // blink, phase still off
      push_render(8'hff, 4'hf, 1'b1, 5'd31, 1'b1);   // row beyond the cell
      push_render(8'h55, 4'h7, 1'b0, 5'd19, 1'b1);
      pending_requests.push_back('{KIND_TICK, '0});
      push_render(8'h0f, 4'h3, 1'b1, 5'd15, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_settings(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0,  5'd31);
            1: apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 5'd0);
            2: apply_settings(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 5'd2,  5'd20);
            3: apply_settings(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 5'd5,  5'd9);
            default: begin
               top = 5'($urandom_range(0, 19));
               apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                              top, 5'(top + $urandom_range(0, 12)));
            end
         endcase
         // back-to-back stretches on both sides
         req_no_gaps = (phase == 1 || phase == 5);
         rsp_no_gaps = (phase == 1 || phase == 5);
         case (phase)
            0: begin
               // 200-line cursor edges: underline row, start and end of cell, beyond
               push_render(8'h18, 4'h2, 1'b0, 5'd7,  1'b1);
               push_render(8'h18, 4'h0, 1'b0, 5'd0,  1'b1);
               push_render(8'h18, 4'h0, 1'b0, 5'd8,  1'b1);
               push_render(8'h18, 4'h1, 1'b0, 5'd31, 1'b1);
               push_random(70);
            end
            2: begin
               // receiver holds off while requests keep coming
               push_random(30);
               @(posedge clock);
               hold_left = HOLD_CYCLES;
               push_random(45);
            end
            3: begin
               // sender pauses until every result is back
               push_random(35);
               wait_idle();
               push_random(35);
            end
            default: push_random(75);
         endcase
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (row_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/tcr_pkg.sv
rtl/text_cell_row_renderer.sv
rtl/tcr_checker.sv
bench/text_cell_row_renderer_tb.sv
